/* rtl/zcr_pkg.sv */
package zcr_pkg;

	localparam int DEF_CANVAS_WIDTH  = 64;
	localparam int DEF_CANVAS_HEIGHT = 64;
	localparam int DEF_FRAME_COUNT   = 8;
	localparam int DEF_PALETTE_DEPTH = 256;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 72;

	localparam logic [1:0] CMD_WR_PIX = 2'd0;
	localparam logic [1:0] CMD_RD_PIX = 2'd1;
	localparam logic [1:0] CMD_RENDER = 2'd2;
	localparam logic [1:0] CMD_WR_PAL = 2'd3;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_RECT  = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] CFG_VIEW_WIDTH  = 3'd2;
	localparam logic [2:0] CFG_VIEW_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_ZOOM_SIZE   = 3'd4;
	localparam logic [2:0] CFG_GRID_ON     = 3'd5;
	localparam logic [2:0] CFG_TRANSPARENT = 3'd6;
	localparam logic [2:0] CFG_FRAME_SEL   = 3'd7;

	typedef struct packed {
		logic [12:0] origin_x;
		logic [12:0] origin_y;
		logic [11:0] view_width;
		logic [11:0] view_height;
		logic [5:0]  zoom_size;
		logic        grid_on;
		logic [8:0]  transparent_index;
		logic [2:0]  frame_select;
	} cfg_t;

	typedef enum logic [2:0] {
		PUSH_NONE,
		PUSH_PEND,
		PUSH_PEND_LAST,
		PUSH_EMPTY,
		PUSH_SINGLE
	} push_t;

	typedef struct packed {
		logic       load_in;
		logic       clear_en;
		logic       wr_pix;
		logic       wr_pal;
		logic       rd_pix;
		logic       div_start;
		logic [1:0] div_sel;
		logic       win_load;
		logic       col_rd;
		logic       pal_rd;
		logic       col_inc;
		logic       pend_load;
		push_t      push;
	} ctrl_t;

	typedef struct packed {
		logic       clear_done;
		logic [1:0] cmd;
		logic       div_done;
		logic       win_empty;
		logic       col_last;
		logic       pix_transparent;
		logic       pend_valid;
		logic       out_free;
	} stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_RESP,
		ST_DIV,
		ST_DIVW,
		ST_WIN,
		ST_PIX,
		ST_PAL,
		ST_EMIT,
		ST_END
	} state_t;

endpackage

/* rtl/zcr_div.sv */
module zcr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [13:0] num,
	input  logic [6:0]         den,
	output logic               done,
	output logic signed [13:0] quo
);
	localparam int NUM_W = 13;
	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [NUM_W-1:0] num_q;
	logic [6:0]       rem_q;
	logic [6:0]       den_q;
	logic [13:0]      mag;
	logic [7:0]       trial;
	logic             fits;

	assign mag   = num[13] ? 14'(-num) : 14'(num);
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= mag[NUM_W-1:0];
			rem_q <= '0;
			neg_q <= num[13];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 7'(trial - {1'b0, den_q}) : trial[6:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
endmodule

/* rtl/zcr_datapath.sv */
module zcr_datapath #(
	parameter int CANVAS_WIDTH  = zcr_pkg::DEF_CANVAS_WIDTH,
	parameter int CANVAS_HEIGHT = zcr_pkg::DEF_CANVAS_HEIGHT,
	parameter int FRAME_COUNT   = zcr_pkg::DEF_FRAME_COUNT,
	parameter int PALETTE_DEPTH = zcr_pkg::DEF_PALETTE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  zcr_pkg::cfg_t                   cfg,
	input  logic [zcr_pkg::IN_DATA_W-1:0]   in_data,
	input  logic [1:0]                      in_user,
	input  zcr_pkg::ctrl_t                  ctl,
	output zcr_pkg::stat_t                  stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [zcr_pkg::OUT_DATA_W-1:0]  out_data,
	output logic [1:0]                      out_kind,
	output logic                            out_last
);
	import zcr_pkg::*;

	localparam int FRAME_SIZE = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int PIX_DEPTH  = FRAME_SIZE * FRAME_COUNT;
	localparam int PIX_AW     = $clog2(PIX_DEPTH);
	localparam int PAL_AW     = $clog2(PALETTE_DEPTH);
	localparam int COL_W      = $clog2(CANVAS_WIDTH);
	localparam int ROW_W      = $clog2(CANVAS_HEIGHT);
	localparam int CLR_LEN    = (PIX_DEPTH > PALETTE_DEPTH) ? PIX_DEPTH : PALETTE_DEPTH;
	localparam int CLR_W      = $clog2(CLR_LEN);

	logic [1:0]         cmd_q;
	logic signed [15:0] px_q, py_q;
	logic [7:0]         val_q;
	logic [23:0]        rgb_q;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= in_user;
			px_q  <= in_data[15:0];
			py_q  <= in_data[31:16];
			val_q <= in_data[39:32];
			rgb_q <= {in_data[47:40], in_data[55:48], in_data[63:56]};
		end
	end

	logic [5:0] size;
	logic [6:0] step;
	assign size = (cfg.zoom_size == 6'd0) ? 6'd1 : cfg.zoom_size;
	assign step = {1'b0, size} + 7'(cfg.grid_on);

	logic inb, frame_ok;
	assign inb = !px_q[15] && (px_q < 16'(CANVAS_WIDTH))
		&& !py_q[15] && (py_q < 16'(CANVAS_HEIGHT));
	assign frame_ok = 32'(cfg.frame_select) < FRAME_COUNT;

	// clearing sweep
	logic [CLR_W-1:0] clr_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (ctl.clear_en) clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	logic [COL_W-1:0] col_q;
	logic [COL_W:0]   x1_q;
	logic [13:0]      ry_q;
	logic [13:0]      new_rx_q;

	logic [PIX_AW-1:0] cmd_addr, col_addr, pix_wa, pix_ra;
	logic [7:0]        pix_wd;
	logic              pix_we, pix_re;
	assign cmd_addr = PIX_AW'(32'(cfg.frame_select) * FRAME_SIZE
		+ 32'(py_q[ROW_W-1:0]) * CANVAS_WIDTH + 32'(px_q[COL_W-1:0]));
	assign col_addr = PIX_AW'(32'(cfg.frame_select) * FRAME_SIZE
		+ 32'(py_q[ROW_W-1:0]) * CANVAS_WIDTH + 32'(col_q));
	assign pix_wa = ctl.clear_en ? clr_cnt_q[PIX_AW-1:0] : cmd_addr;
	assign pix_wd = ctl.clear_en ? 8'd0 : val_q;
	assign pix_we = (ctl.clear_en && (32'(clr_cnt_q) < PIX_DEPTH))
		|| (ctl.wr_pix && inb && frame_ok);
	assign pix_ra = ctl.rd_pix ? cmd_addr : col_addr;
	assign pix_re = ctl.rd_pix || ctl.col_rd;

	logic [7:0] pix_mem [PIX_DEPTH];
	logic [7:0] pix_rd_q;
	logic       pix_zero_q;
	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[pix_wa] <= pix_wd;
		if (pix_re) begin
			pix_rd_q   <= pix_mem[pix_ra];
			pix_zero_q <= !frame_ok;
		end
	end

	logic [7:0] pix_val;
	assign pix_val = pix_zero_q ? 8'd0 : pix_rd_q;

	logic [PAL_AW-1:0] pal_wa;
	logic [23:0]       pal_wd;
	logic              pal_we;
	assign pal_wa = ctl.clear_en ? clr_cnt_q[PAL_AW-1:0] : val_q[PAL_AW-1:0];
	assign pal_wd = ctl.clear_en ? 24'd0 : rgb_q;
	assign pal_we = (ctl.clear_en && (32'(clr_cnt_q) < PALETTE_DEPTH))
		|| (ctl.wr_pal && (32'(val_q) < PALETTE_DEPTH));

	logic [23:0] pal_mem [PALETTE_DEPTH];
	logic [23:0] pal_rd_q;
	logic        pal_zero_q;
	always_ff @(posedge clk) begin
		if (pal_we) pal_mem[pal_wa] <= pal_wd;
		if (ctl.pal_rd) begin
			pal_rd_q   <= pal_mem[pix_val[PAL_AW-1:0]];
			pal_zero_q <= !(32'(pix_val) < PALETTE_DEPTH);
		end
	end

	// window divisions
	logic signed [13:0] nox, noy, div_num, div_quo;
	logic               div_done;
	assign nox = -$signed({cfg.origin_x[12], cfg.origin_x});
	assign noy = -$signed({cfg.origin_y[12], cfg.origin_y});
	always_comb begin
		case (ctl.div_sel)
			2'd0:    div_num = nox;
			2'd1:    div_num = noy;
			2'd2:    div_num = nox + $signed({2'b00, cfg.view_width});
			default: div_num = noy + $signed({2'b00, cfg.view_height});
		endcase
	end

	zcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (div_num),
		.den    (step),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic signed [13:0] quo_q [4];
	always_ff @(posedge clk) begin
		if (div_done) quo_q[ctl.div_sel] <= div_quo;
	end

	logic signed [15:0] x0_w, x1_w, y0_w, y1_w, x1_t, y1_t;
	logic               win_vis;
	assign x0_w = quo_q[0][13] ? 16'sd0 : 16'(quo_q[0]);
	assign y0_w = quo_q[1][13] ? 16'sd0 : 16'(quo_q[1]);
	assign x1_t = 16'(quo_q[2]) + 16'sd1;
	assign y1_t = 16'(quo_q[3]) + 16'sd1;
	assign x1_w = (x1_t > $signed(16'(CANVAS_WIDTH))) ? $signed(16'(CANVAS_WIDTH)) : x1_t;
	assign y1_w = (y1_t > $signed(16'(CANVAS_HEIGHT))) ? $signed(16'(CANVAS_HEIGHT)) : y1_t;
	assign win_vis = (py_q >= y0_w) && (py_q < y1_w) && (x0_w < x1_w);

	logic [13:0] rx_w, ry_w;
	assign rx_w = {cfg.origin_x[12], cfg.origin_x} + 14'(32'(col_q) * 32'(step))
		+ 14'(cfg.grid_on);
	assign ry_w = {cfg.origin_y[12], cfg.origin_y}
		+ 14'(32'(py_q[ROW_W-1:0]) * 32'(step)) + 14'(cfg.grid_on);

	always_ff @(posedge clk) begin
		if (ctl.win_load) begin
			col_q <= x0_w[COL_W-1:0];
			x1_q  <= x1_w[COL_W:0];
			ry_q  <= ry_w;
		end else if (ctl.col_inc) begin
			col_q <= col_q + 1'b1;
		end
		if (ctl.pal_rd) new_rx_q <= rx_w;
	end

	// pending rectangle: held back until it is known whether it is the last
	logic        pend_valid_q;
	logic [13:0] pend_rx_q, pend_ry_q;
	logic [5:0]  pend_size_q;
	logic [23:0] pend_rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_valid_q <= 1'b0;
		else if (ctl.pend_load) pend_valid_q <= 1'b1;
		else if (ctl.push == PUSH_PEND_LAST) pend_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.pend_load) begin
			pend_rx_q   <= new_rx_q;
			pend_ry_q   <= ry_q;
			pend_size_q <= size;
			pend_rgb_q  <= pal_zero_q ? 24'd0 : pal_rd_q;
		end
	end

	// output register
	logic        out_valid_q, out_last_q;
	logic [1:0]  out_kind_q;
	logic [8:0]  out_rv_q;
	logic [13:0] out_rx_q, out_ry_q;
	logic [5:0]  out_size_q;
	logic [23:0] out_rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ctl.push != PUSH_NONE) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (ctl.push)
			PUSH_PEND, PUSH_PEND_LAST: begin
				out_kind_q <= KIND_RECT;
				out_rv_q   <= '0;
				out_rx_q   <= pend_rx_q;
				out_ry_q   <= pend_ry_q;
				out_size_q <= pend_size_q;
				out_rgb_q  <= pend_rgb_q;
				out_last_q <= (ctl.push == PUSH_PEND_LAST);
			end
			PUSH_EMPTY: begin
				out_kind_q <= KIND_EMPTY;
				out_rv_q   <= '0;
				out_rx_q   <= '0;
				out_ry_q   <= '0;
				out_size_q <= '0;
				out_rgb_q  <= '0;
				out_last_q <= 1'b1;
			end
			PUSH_SINGLE: begin
				out_kind_q <= (cmd_q == CMD_RD_PIX) ? KIND_READ : KIND_ACK;
				out_rv_q   <= (cmd_q != CMD_RD_PIX) ? 9'd0 : (inb ? {1'b0, pix_val} : 9'h1FF);
				out_rx_q   <= '0;
				out_ry_q   <= '0;
				out_size_q <= '0;
				out_rgb_q  <= '0;
				out_last_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;
	assign out_data  = {5'd0, out_rgb_q[7:0], out_rgb_q[15:8], out_rgb_q[23:16],
		out_size_q, out_ry_q, out_rx_q, out_rv_q};

	always_comb begin
		stat.clear_done      = clr_cnt_q == CLR_W'(CLR_LEN - 1);
		stat.cmd             = cmd_q;
		stat.div_done        = div_done;
		stat.win_empty       = !win_vis;
		stat.col_last        = ({1'b0, col_q} + 1'b1) >= x1_q;
		stat.pix_transparent = {1'b0, pix_val} == cfg.transparent_index;
		stat.pend_valid      = pend_valid_q;
		stat.out_free        = !out_valid_q || out_ready;
	end
endmodule

/* rtl/zcr_ctrl.sv */
module zcr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_user,
	output logic           in_ready,
	input  zcr_pkg::stat_t stat,
	output zcr_pkg::ctrl_t ctl
);
	import zcr_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] div_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			div_sel_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIVW && stat.div_done) div_sel_q <= div_sel_q + 1'b1;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl         = '0;
		ctl.push    = PUSH_NONE;
		ctl.div_sel = div_sel_q;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_en = 1'b1;
				if (stat.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					case (in_user)
						CMD_RD_PIX: state_d = ST_RD;
						CMD_RENDER: state_d = ST_DIV;
						default:    state_d = ST_WR;
					endcase
				end
			end
			ST_WR: begin
				if (stat.cmd == CMD_WR_PAL) ctl.wr_pal = 1'b1;
				else ctl.wr_pix = 1'b1;
				state_d = ST_RESP;
			end
			ST_RD: begin
				ctl.rd_pix = 1'b1;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					ctl.push = PUSH_SINGLE;
					state_d  = ST_IDLE;
				end
			end
			ST_DIV: begin
				ctl.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (stat.div_done) state_d = (div_sel_q == 2'd3) ? ST_WIN : ST_DIV;
			end
			ST_WIN: begin
				ctl.win_load = 1'b1;
				state_d      = stat.win_empty ? ST_END : ST_PIX;
			end
			ST_PIX: begin
				ctl.col_rd = 1'b1;
				state_d    = ST_PAL;
			end
			ST_PAL: begin
				if (stat.pix_transparent) begin
					ctl.col_inc = 1'b1;
					state_d     = stat.col_last ? ST_END : ST_PIX;
				end else begin
					ctl.pal_rd = 1'b1;
					state_d    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!stat.pend_valid || stat.out_free) begin
					if (stat.pend_valid) ctl.push = PUSH_PEND;
					ctl.pend_load = 1'b1;
					ctl.col_inc   = 1'b1;
					state_d       = stat.col_last ? ST_END : ST_PIX;
				end
			end
			ST_END: begin
				if (stat.out_free) begin
					ctl.push = stat.pend_valid ? PUSH_PEND_LAST : PUSH_EMPTY;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

/* rtl/zoomed_canvas_rect_renderer.sv */
// Zoomed canvas rectangle renderer.
// Commands arrive one beat at a time on the s_axis channel (tuser = command):
// write pixel, read pixel, write palette entry, or render one canvas row.
// Results leave on m_axis (tuser = result kind); tlast marks the final beat
// of a command. Writes and reads give one beat; a render gives one rectangle
// beat per visible opaque pixel, or a single empty-row beat.
// Registers are written on the cfg channel (always ready); the user must write
// them only while idle, as the block itself does not enforce it.
// A write or a pixel read steps through ST_WR or ST_RD, then ST_RESP.
// A render runs four window divisions on one shared shift-subtract divider,
// then walks the visible columns: each pixel takes a pixel store read, and
// a drawn one then a palette read and an emit step. One command is in flight.
// After reset a clearing pass zeroes the pixel store and the palette, one
// entry a cycle, over max(FRAME_COUNT*CANVAS_WIDTH*CANVAS_HEIGHT, PALETTE_DEPTH)
// entries (32768 with the defaults); s_axis_tready stays low until it ends.
// A stalled receiver holds the output register; the render stops at its
// next rectangle until the beat is taken, and nothing is dropped.
module zoomed_canvas_rect_renderer #(
	parameter int CANVAS_WIDTH  = zcr_pkg::DEF_CANVAS_WIDTH,
	parameter int CANVAS_HEIGHT = zcr_pkg::DEF_CANVAS_HEIGHT,
	parameter int FRAME_COUNT   = zcr_pkg::DEF_FRAME_COUNT,
	parameter int PALETTE_DEPTH = zcr_pkg::DEF_PALETTE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x[15:0], pos_y[31:16], value[39:32], in_red, in_green, in_blue
	input  logic [63:0] s_axis_tdata,
	// cmd
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_value[8:0], rect_x[22:9], rect_y[36:23], rect_size[42:37],
	// out_red[50:43], out_green[58:51], out_blue[66:59], zero fill
	output logic [71:0] m_axis_tdata,
	// kind
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import zcr_pkg::*;

	cfg_t  cfg_q;
	ctrl_t ctl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// register file; each write keeps the low bits of the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x          <= 13'd0;
			cfg_q.origin_y          <= 13'd0;
			cfg_q.view_width        <= 12'd640;
			cfg_q.view_height       <= 12'd480;
			cfg_q.zoom_size         <= 6'd1;
			cfg_q.grid_on           <= 1'b0;
			cfg_q.transparent_index <= 9'h1FF;
			cfg_q.frame_select      <= 3'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN_X:    cfg_q.origin_x          <= cfg_data;
				CFG_ORIGIN_Y:    cfg_q.origin_y          <= cfg_data;
				CFG_VIEW_WIDTH:  cfg_q.view_width        <= cfg_data[11:0];
				CFG_VIEW_HEIGHT: cfg_q.view_height       <= cfg_data[11:0];
				CFG_ZOOM_SIZE:   cfg_q.zoom_size         <= cfg_data[5:0];
				CFG_GRID_ON:     cfg_q.grid_on           <= cfg_data[0];
				CFG_TRANSPARENT: cfg_q.transparent_index <= cfg_data[8:0];
				CFG_FRAME_SEL:   cfg_q.frame_select      <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// sequence the command
	zcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_user  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// stores, divider, window and output register
	zcr_datapath #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT),
		.FRAME_COUNT   (FRAME_COUNT),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// every non-rectangle beat closes its command
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_RECT) |-> m_axis_tlast)
		else $error("non-rectangle beat without tlast");

	// one command in flight: no accept in the cycle after an accept
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command accepted back to back");

	// a rectangle never has zero size
	a_rect_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_RECT) |-> (m_axis_tdata[42:37] != 6'd0))
		else $error("rectangle with zero size");
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

// Testbench for the zoomed canvas rectangle renderer.
// Commands go in on s_axis, results come back on m_axis. A behavioral copy of
// the pixel store, palette and registers predicts every result beat; a monitor
// compares each accepted beat with the oldest prediction. Directed tests cover
// the field extremes, each command and the corner cases. Random traffic covers
// pixel, palette and render commands under several register settings, with a
// bursty sender and a stalling receiver.
module tb;
	import zcr_pkg::*;

	localparam int CW = DEF_CANVAS_WIDTH;
	localparam int CH = DEF_CANVAS_HEIGHT;
	localparam int FC = DEF_FRAME_COUNT;
	localparam int PD = DEF_PALETTE_DEPTH;
	localparam int IDLE_LIMIT = 100000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  read_value;
		logic [13:0] rect_x;
		logic [13:0] rect_y;
		logic [5:0]  rect_size;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last;
	} beat_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [71:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [12:0] cfg_data = '0;

	zoomed_canvas_rect_renderer dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Shadow state
	logic [7:0]  pix_mem [FC*CW*CH];
	logic [23:0] pal_mem [PD];
	logic signed [12:0] org_x, org_y;
	logic [11:0] vw, vh;
	logic [5:0]  zoom;
	logic        grid;
	logic signed [8:0] transp;
	logic [2:0]  frame;

	beat_t expected_beats[$];
	int errors = 0;
	int beats_seen = 0;
	int rects_seen = 0;
	int cmds_sent = 0;
	int idle_cycles = 0;
	bit recv_stall_mode = 0;
	bit gaps_on = 1;

	task automatic report(string what);
		errors++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic bit on_canvas(int x, int y);
		return x >= 0 && x < CW && y >= 0 && y < CH;
	endfunction

	function automatic int pix_value(int x, int y);
		if (frame >= FC) return 0;
		return pix_mem[frame*CW*CH + y*CW + x];
	endfunction

	function automatic beat_t simple_beat(logic [1:0] k, logic [8:0] rv);
		beat_t b = '0;
		b.kind = k;
		b.read_value = rv;
		b.last = 1;
		return b;
	endfunction

	// Work out the beats of one command and update the shadow state.
	task automatic predict_command(logic [1:0] cmd, logic [15:0] px16, logic [15:0] py16,
			logic [7:0] val, logic [23:0] rgb);
		int px, py, sz, stp, x0, y0, x1, y1, n, l;
		beat_t b;
		px = $signed(px16);
		py = $signed(py16);
		case (cmd)
		CMD_WR_PIX: begin
			if (on_canvas(px, py) && frame < FC) pix_mem[frame*CW*CH + py*CW + px] = val;
			expected_beats.push_back(simple_beat(KIND_ACK, 0));
		end
		CMD_RD_PIX:
			expected_beats.push_back(simple_beat(KIND_READ,
				on_canvas(px, py) ? 9'(pix_value(px, py)) : 9'h1FF));
		CMD_WR_PAL: begin
			if (val < PD) pal_mem[val] = rgb;
			expected_beats.push_back(simple_beat(KIND_ACK, 0));
		end
		default: begin
			sz = (zoom == 0) ? 1 : zoom;
			stp = sz + grid;
			x0 = (-int'(org_x)) / stp;
			y0 = (-int'(org_y)) / stp;
			x1 = (-int'(org_x) + int'(vw)) / stp + 1;
			y1 = (-int'(org_y) + int'(vh)) / stp + 1;
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > CW) x1 = CW;
			if (y1 > CH) y1 = CH;
			n = 0;
			if (py >= y0 && py < y1) begin
				for (int i = x0; i < x1; i++) begin
					l = pix_value(i, py);
					if (l == int'(transp)) continue;
					b = '0;
					b.kind = KIND_RECT;
					b.rect_x = 14'(int'(org_x) + i*stp + grid);
					b.rect_y = 14'(int'(org_y) + py*stp + grid);
					b.rect_size = 6'(sz);
					{b.red, b.green, b.blue} = (l < PD) ? pal_mem[l] : 24'h0;
					expected_beats.push_back(b);
					n++;
				end
			end
			if (n == 0) expected_beats.push_back(simple_beat(KIND_EMPTY, 0));
			else expected_beats[$].last = 1;
		end
		endcase
	endtask

	// Send one command beat, with a random gap before it when gaps are on.
	task automatic send_command(logic [1:0] cmd, logic [15:0] px, logic [15:0] py,
			logic [7:0] val, logic [23:0] rgb = 24'h0);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		predict_command(cmd, px, py, val, rgb);
		s_axis_tuser <= cmd;
		s_axis_tdata <= {rgb[7:0], rgb[15:8], rgb[23:16], val, py, px};
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		cmds_sent++;
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	task automatic wait_drained();
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// Registers are written only while the block is idle.
	task automatic write_reg(logic [2:0] idx, logic [12:0] data);
		wait_drained();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		case (idx)
		CFG_ORIGIN_X:    org_x = data;
		CFG_ORIGIN_Y:    org_y = data;
		CFG_VIEW_WIDTH:  vw = data[11:0];
		CFG_VIEW_HEIGHT: vh = data[11:0];
		CFG_ZOOM_SIZE:   zoom = data[5:0];
		CFG_GRID_ON:     grid = data[0];
		CFG_TRANSPARENT: transp = data[8:0];
		default:         frame = data[2:0];
		endcase
	endtask

	task automatic set_view(int ox, int oy, int w, int h, int z, int g, int t, int f);
		write_reg(CFG_ORIGIN_X, 13'(ox));
		write_reg(CFG_ORIGIN_Y, 13'(oy));
		write_reg(CFG_VIEW_WIDTH, 13'(w));
		write_reg(CFG_VIEW_HEIGHT, 13'(h));
		write_reg(CFG_ZOOM_SIZE, 13'(z));
		write_reg(CFG_GRID_ON, 13'(g));
		write_reg(CFG_TRANSPARENT, 13'(t));
		write_reg(CFG_FRAME_SEL, 13'(f));
	endtask

	// Pick a coordinate: mostly on the canvas, sometimes far outside.
	function automatic logic [15:0] rand_coord(int lim);
		case ($urandom_range(0, 9))
		0: return 16'($urandom);
		1: return 16'(-$urandom_range(1, 3));
		2: return 16'(lim + $urandom_range(0, 3));
		default: return 16'($urandom_range(0, lim - 1));
		endcase
	endfunction

	task automatic test_pixel_access();
		send_command(CMD_RD_PIX, 0, 0, 0);
		send_command(CMD_WR_PIX, 0, 0, 8'hFF);
		send_command(CMD_WR_PIX, CW-1, CH-1, 8'hA5);
		send_command(CMD_WR_PIX, 16'h8000, 16'h7FFF, 8'h11);
		send_command(CMD_WR_PIX, CW, 0, 8'h22);
		send_command(CMD_RD_PIX, 0, 0, 0);
		send_command(CMD_RD_PIX, CW-1, CH-1, 0);
		send_command(CMD_RD_PIX, 16'hFFFF, 0, 0);
		send_command(CMD_RD_PIX, 0, CH, 0);
		send_command(CMD_RD_PIX, 16'h7FFF, 16'h8000, 0);
	endtask

	task automatic test_palette_and_render();
		send_command(CMD_WR_PAL, 0, 0, 8'hFF, 24'hFFFFFF);
		send_command(CMD_WR_PAL, 0, 0, 8'hA5, 24'h5AC30F);
		send_command(CMD_WR_PAL, 0, 0, 8'h00, 24'h123456);
		send_command(CMD_RENDER, 0, 0, 0);
		send_command(CMD_RENDER, 0, CH-1, 0);
		send_command(CMD_RENDER, 0, 16'hFFFF, 0);
		send_command(CMD_RENDER, 0, CH, 0);
	endtask

	// Transparency, zoom extremes, grid, off-screen origin, empty window,
	// frame selection.
	task automatic test_corner_settings();
		set_view(-4096, 4095, 4095, 0, 0, 1, 255, 7);
		send_command(CMD_RENDER, 0, 0, 0);
		set_view(-40, -8, 100, 50, 32, 1, 0, 3);
		send_command(CMD_WR_PIX, 2, 0, 8'h00);
		send_command(CMD_WR_PIX, 3, 0, 8'hA5);
		send_command(CMD_RENDER, 0, 0, 0);
		set_view(4095, 0, 0, 4095, 63, 0, -1, 0);
		send_command(CMD_RENDER, 0, 0, 0);
		set_view(-4096, -4096, 4095, 4095, 1, 0, 0, 0);
		send_command(CMD_RENDER, 0, CH-1, 0);
	endtask

	task automatic test_random_traffic(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				set_view($urandom_range(0, 3) == 0 ? -$urandom_range(0, 4096) :
					$urandom_range(0, 200), $urandom_range(0, 3) == 0 ?
					-$urandom_range(0, 4096) : $urandom_range(0, 200),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 63), $urandom_range(0, 1),
					$urandom_range(0, 4) == 0 ? -1 : $urandom_range(0, 255),
					$urandom_range(0, 7));
			if (i == count / 2) begin
				// Hold the sender until every result is in.
				wait_drained();
				gaps_on = ~gaps_on;
			end
			r = $urandom_range(0, 9);
			if (r < 4) send_command(CMD_WR_PIX, rand_coord(CW), rand_coord(CH),
				$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)));
			else if (r < 6) send_command(CMD_RD_PIX, rand_coord(CW), rand_coord(CH), 0);
			else if (r < 7) send_command(CMD_WR_PAL, 16'($urandom), 16'($urandom),
				$urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 7)),
				24'($urandom));
			else send_command(CMD_RENDER, 16'($urandom), rand_coord(CH), 8'($urandom));
		end
	endtask

	// Receiver: alternate between stretches of random stalls and no stalls.
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0) recv_stall_mode <= ~recv_stall_mode;
		m_axis_tready <= arst_n && (!recv_stall_mode || $urandom_range(0, 2) != 0);
	end

	// Compare each result beat with the oldest prediction.
	always @(posedge clk) begin
		beat_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			{got.blue, got.green, got.red, got.rect_size, got.rect_y, got.rect_x,
				got.read_value} = m_axis_tdata[66:0];
			got.last = m_axis_tlast;
			beats_seen++;
			if (got.kind == KIND_RECT) rects_seen++;
			if (m_axis_tdata[71:67] != 0) report("nonzero fill bits in result");
			if (expected_beats.size() == 0) report($sformatf("unexpected beat %p", got));
			else begin
				want = expected_beats.pop_front();
				if (got.kind != want.kind)
					report($sformatf("kind %0d, want %0d", got.kind, want.kind));
				if (got.read_value != want.read_value)
					report($sformatf("read_value %0h, want %0h", got.read_value,
						want.read_value));
				if (got.rect_x != want.rect_x)
					report($sformatf("rect_x %0h, want %0h", got.rect_x, want.rect_x));
				if (got.rect_y != want.rect_y)
					report($sformatf("rect_y %0h, want %0h", got.rect_y, want.rect_y));
				if (got.rect_size != want.rect_size)
					report($sformatf("rect_size %0d, want %0d", got.rect_size,
						want.rect_size));
				if ({got.red, got.green, got.blue} != {want.red, want.green, want.blue})
					report($sformatf("colour %h, want %h", {got.red, got.green, got.blue},
						{want.red, want.green, want.blue}));
				if (got.last != want.last)
					report($sformatf("last %0d, want %0d", got.last, want.last));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long. The clearing
	// pass after reset is well within the limit.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		foreach (pix_mem[i]) pix_mem[i] = 0;
		foreach (pal_mem[i]) pal_mem[i] = 0;
		org_x = 0; org_y = 0; vw = 640; vh = 480;
		zoom = 1; grid = 0; transp = -1; frame = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_pixel_access();
		test_palette_and_render();
		test_corner_settings();
		test_random_traffic(440);
		// Leave the last setting at reset values to end on a known state.
		set_view(0, 0, 640, 480, 1, 0, -1, 0);
		send_command(CMD_RENDER, 0, CH-1, 0);
		wait_drained();
		$display("Covered %0d commands and %0d result beats (%0d rectangles)",
			cmds_sent, beats_seen, rects_seen);
		$display("under several register settings, with sender gaps and receiver stalls");
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

/* files.f */
rtl/zcr_pkg.sv
rtl/zcr_div.sv
rtl/zcr_datapath.sv
rtl/zcr_ctrl.sv
rtl/zoomed_canvas_rect_renderer.sv
dv/tb.sv
